FILE: hdl/sha_pkg.sv
// SHA-256 stream hasher package: constants, types and round functions.
`default_nettype none
package sha_pkg;
    localparam logic [1:0] OP_ABSORB = 2'd0;
    localparam logic [1:0] OP_DIGEST = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;

    localparam int BUF_DEPTH = 64;
    localparam int BUF_AW    = 6;
    localparam int CNT_W     = 61;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    typedef logic [31:0] t_word;

    // command from controller to datapath
    typedef struct packed {
        logic       load_iv;      // chaining <= IV
        logic       clr_count;
        logic       buf_wr;       // write input byte to buffer, count it
        logic       blk_begin;    // load working vars from chaining or scratch, clear round index
        logic       src_work;     // blocks start from scratch hv instead of chaining
        logic       scr_from_ch;  // scratch hv <= chaining
        logic       fetch;        // read one buffer byte
        logic [BUF_AW-1:0] fetch_addr;
        logic       round;        // one compression round
        logic       fin_chain;    // add working vars into chaining
        logic       fin_scr;      // add working vars into scratch
        logic       pad_second;   // block being fed is the length-only block
        logic       out_load;     // present digest word
        logic [2:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic       full_next;    // this absorb completes a block
        logic       two_blocks;   // fill >= 56
    } t_sts;

    localparam t_word IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam t_word K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

FILE: hdl/sha_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none
module sha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/sha_datapath.sv
// SHA-256 datapath: byte buffer, message schedule, round unit, chaining words.
`default_nettype none
module sha_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sha_pkg::t_cmd    i_cmd,
    input  wire logic [7:0]       i_data_byte,
    output sha_pkg::t_sts         o_sts,
    output logic [31:0]           o_digest_word
);
    logic [sha_pkg::CNT_W-1:0] r_count;
    sha_pkg::t_word r_ch  [8];
    sha_pkg::t_word r_scr [8];
    sha_pkg::t_word r_v   [8];
    sha_pkg::t_word r_w   [16];
    logic [5:0]  r_t;       // round index
    logic [31:0] r_acc;
    logic [5:0]  r_raddr_q;
    logic        r_rd_valid;
    logic [7:0]  rdata;
    logic [5:0]  raddr;
    logic [5:0]  fill;
    logic [7:0]  pad_b;
    logic [63:0] bits;
    sha_pkg::t_word wt, s0, s1, b0, b1, mj, ch, x1, x2, wnew;
    logic [2:0]  bi;

    assign fill  = r_count[5:0];
    assign bits  = {r_count, 3'b000};
    assign raddr = i_cmd.fetch_addr;
    assign o_sts.full_next  = (fill == 6'd63);
    assign o_sts.two_blocks = (fill >= sha_pkg::LEN_POS);

    sha_ram #(.WIDTH(8), .DEPTH(sha_pkg::BUF_DEPTH)) u_buf (
        .i_clk(i_clk), .i_we(i_cmd.buf_wr), .i_waddr(fill), .i_wdata(i_data_byte),
        .i_raddr(raddr), .o_rdata(rdata));

    // padded byte at the address read last cycle
    always_comb begin
        bi = 3'(r_raddr_q - sha_pkg::LEN_POS);
        if (i_cmd.pad_second) begin
            pad_b = 8'h00;
        end else if (r_raddr_q < fill) begin
            pad_b = rdata;
        end else if (r_raddr_q == fill) begin
            pad_b = sha_pkg::PAD_BYTE;
        end else begin
            pad_b = 8'h00;
        end
        if (!i_cmd.src_work) pad_b = rdata;
        if (i_cmd.src_work && r_raddr_q >= sha_pkg::LEN_POS
            && (i_cmd.pad_second || fill < sha_pkg::LEN_POS)) begin
            pad_b = bits[8*(7-bi) +: 8];
        end
    end

    always_comb begin
        wt   = r_w[0];
        s0   = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1   = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        wnew = r_w[0] + s0 + r_w[9] + s1;
        b0   = sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13) ^ sha_pkg::rotr(r_v[0], 22);
        b1   = sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11) ^ sha_pkg::rotr(r_v[4], 25);
        mj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        x1   = r_v[7] + b1 + ch + sha_pkg::K[r_t] + wt;
        x2   = b0 + mj;
    end

    always_ff @(posedge i_clk) begin
        r_raddr_q  <= raddr;
        r_rd_valid <= i_cmd.fetch;
        if (!i_rst_n) begin
            r_count <= '0;
            r_t     <= '0;
            for (int i = 0; i < 8; i++) r_ch[i] <= sha_pkg::IV[i];
        end else begin
            if (i_cmd.load_iv) for (int i = 0; i < 8; i++) r_ch[i] <= sha_pkg::IV[i];
            if (i_cmd.clr_count) r_count <= '0;
            if (i_cmd.buf_wr) r_count <= r_count + 1'b1;
            if (i_cmd.scr_from_ch) for (int i = 0; i < 8; i++) r_scr[i] <= r_ch[i];
            if (i_cmd.blk_begin) begin
                r_t  <= '0;
                for (int i = 0; i < 8; i++) r_v[i] <= i_cmd.src_work ? r_scr[i] : r_ch[i];
            end
            // byte arrives in the cycle after its read address
            if (r_rd_valid) begin
                if (r_raddr_q[1:0] == 2'd3) begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= {r_acc[23:0], pad_b};
                end else begin
                    r_acc <= {r_acc[23:0], pad_b};
                end
            end
            if (i_cmd.round) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= wnew;
                r_t  <= r_t + 1'b1;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + x1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= x1 + x2;
            end
            if (i_cmd.fin_chain) for (int i = 0; i < 8; i++) r_ch[i] <= r_ch[i] + r_v[i];
            if (i_cmd.fin_scr) for (int i = 0; i < 8; i++) r_scr[i] <= r_scr[i] + r_v[i];
        end
        if (i_cmd.out_load) o_digest_word <= r_scr[i_cmd.out_idx];
    end
endmodule
`default_nettype wire

FILE: hdl/sha_ctrl.sv
// SHA-256 controller: handshakes, block fetch, round count and digest sequencing.
`default_nettype none
module sha_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [1:0]    i_operation,
    input  wire sha_pkg::t_sts i_sts,
    output sha_pkg::t_cmd      o_cmd,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [2:0]         o_word_index,
    output logic               o_last_word
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       r_dig, n_dig;        // working on a digest
    logic       r_second, n_second;  // digest: length-only block pending/active
    logic       r_two, n_two;
    logic [2:0] r_oi, n_oi;
    logic       r_ov, n_ov;
    logic       acc;

    assign o_stall = (r_state != S_IDLE) || r_ov;
    assign acc     = i_valid && !o_stall;
    assign o_valid = r_ov;
    assign o_word_index = r_oi;
    assign o_last_word  = (r_oi == 3'd7);

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_dig = r_dig; n_second = r_second;
        n_two = r_two; n_oi = r_oi; n_ov = r_ov;
        o_cmd = '0;
        o_cmd.src_work   = r_dig;
        o_cmd.pad_second = r_second;
        o_cmd.fetch_addr = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_operation)
                        sha_pkg::OP_ABSORB: begin
                            o_cmd.buf_wr = 1'b1;
                            if (i_sts.full_next) begin
                                n_dig = 1'b0; n_second = 1'b0;
                                n_state = S_FETCH; n_cnt = '0;
                            end
                        end
                        sha_pkg::OP_DIGEST: begin
                            o_cmd.scr_from_ch = 1'b1;
                            n_dig = 1'b1; n_second = 1'b0; n_two = i_sts.two_blocks;
                            n_state = S_FETCH; n_cnt = '0;
                        end
                        sha_pkg::OP_RESET: begin
                            o_cmd.load_iv = 1'b1; o_cmd.clr_count = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH: begin
                if (r_cnt == 6'd0) o_cmd.blk_begin = 1'b1;
                o_cmd.fetch = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'd63) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_ROUND; n_cnt = '0;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'd63) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin_chain = !r_dig;
                o_cmd.fin_scr   = r_dig;
                n_cnt = '0;
                if (r_dig && r_two && !r_second) begin
                    n_second = 1'b1; n_state = S_FETCH;
                end else if (r_dig) begin
                    n_state = S_OUT; n_oi = '0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (!r_ov || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_idx  = r_cnt[2:0];
                    n_ov = 1'b1;
                    n_oi = r_cnt[2:0];
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == 6'd7) begin
                        n_state = S_IDLE; n_dig = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_ov && !i_stall && !o_cmd.out_load) n_ov = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_dig <= 1'b0; r_second <= 1'b0;
            r_two <= 1'b0; r_oi <= '0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_dig <= n_dig; r_second <= n_second;
            r_two <= n_two; r_oi <= n_oi; r_ov <= n_ov;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/sha256_stream_hasher.sv
// SHA-256 stream hasher top level.
// An absorb transfer writes one byte into the block buffer RAM; the one that
// completes a 64-byte block is followed by byte reads of the whole block from
// that RAM, a drain state, the compression rounds of the shared round unit and
// an add step before the next transfer is taken. A digest runs one or two
// such padded blocks (two when 56 or more bytes are pending) and then delivers
// eight word transfers, word 0 first. A reset transfer reloads the IV and clears the count.
`default_nettype none
module sha256_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);
    sha_pkg::t_cmd cmd;
    sha_pkg::t_sts sts;

    sha_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation), .i_sts(sts), .o_cmd(cmd), .o_valid(o_valid),
        .i_stall(i_stall), .o_word_index(o_word_index), .o_last_word(o_last_word));

    sha_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_data_byte(i_data_byte),
        .o_sts(sts), .o_digest_word(o_digest_word));
endmodule
`default_nettype wire

FILE: hdl/sha_checker.sv
// Port-level checks for the SHA-256 stream hasher, with its bind.
`default_nettype none
module sha_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_digest_word,
    input wire logic [2:0]  o_word_index,
    input wire logic        o_last_word
);
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last_word mismatch");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digest_word) && $stable(o_word_index))
        else $error("stalled result changed");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_word |=> o_valid && o_word_index == $past(o_word_index) + 3'd1)
        else $error("word sequence broken");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken during digest output");
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (.*);
`default_nettype wire
